/* sv/sorted_key_list_macros.svh */
// Assertion macros for the sorted key list RTL.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef SORTED_KEY_LIST_MACROS_SVH
`define SORTED_KEY_LIST_MACROS_SVH

// Checked on every clock edge outside reset
`define SKL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked on every clock edge, reset included
`define SKL_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* sv/skl_pkg.sv */
// Package for the sorted key list: beat types, opcode and status codes.
// No dependencies; imported by skl_cell, sorted_key_list and the testbench.
`timescale 1ns / 1ps

package skl_pkg;

    localparam int SKL_CAPACITY = 16;
    localparam int KEY_W        = 32;

    // opcodes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_GET    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // request beat
    typedef struct packed {
        logic [1:0]       op;
        logic [KEY_W-1:0] key;
        logic [3:0]       index;
    } t_skl_in;

    // response beat
    typedef struct packed {
        logic [3:0]       position;
        logic [KEY_W-1:0] read_key;
        logic [4:0]       entries;
        logic [1:0]       status;
    } t_skl_out;

    // control broadcast to every cell
    typedef struct packed {
        logic             ins;
        logic             rem;
        logic             desc;
        logic [KEY_W-1:0] key;
        logic [3:0]       idx;
    } t_skl_bcast;

endpackage

/* sv/skl_prefix.sv */
// Parallel prefix AND over the per-cell "precedes" flags of the sorted key list.
// Log-depth network; no package dependency.
`timescale 1ns / 1ps

module skl_prefix #(
    parameter int N = 16
) (
    input  logic [N-1:0] i_prec,
    output logic [N-1:0] o_all
);

    localparam int LV = $clog2(N);

    logic [LV:0][N-1:0] w_lvl;

    assign w_lvl[0] = i_prec;

    // each level folds in the flag 2^l places lower
    for (genvar l = 0; l < LV; l++) begin : g_lvl
        for (genvar i = 0; i < N; i++) begin : g_bit
            if (i >= (1 << l)) begin : g_and
                assign w_lvl[l+1][i] = w_lvl[l][i] & w_lvl[l][i-(1<<l)];
            end else begin : g_pass
                assign w_lvl[l+1][i] = w_lvl[l][i];
            end
        end
    end

    assign o_all = w_lvl[LV];

endmodule

/* sv/skl_cell.sv */
// One storage cell of the sorted key list: holds a key, compares it with
// the broadcast key and shifts with its neighbors. Uses skl_pkg.
`timescale 1ns / 1ps

module skl_cell #(
    parameter int CELL_IDX = 0,
    parameter int CNT_W    = 5
) (
    input  logic                        i_clk,
    input  skl_pkg::t_skl_bcast         i_bc,
    input  logic [CNT_W-1:0]            i_count,
    input  logic [skl_pkg::KEY_W-1:0]   i_left_key,
    input  logic [skl_pkg::KEY_W-1:0]   i_right_key,
    input  logic                        i_pre_prev,
    input  logic                        i_pre_self,
    output logic [skl_pkg::KEY_W-1:0]   o_key,
    output logic                        o_prec,
    output logic [3:0]                  o_pos
);

    import skl_pkg::*;

    logic [KEY_W-1:0] r_key;
    logic [KEY_W-1:0] n_key;
    logic             w_occ;
    logic             w_at_idx;
    logic             w_head;

    // occupancy and position relative to the remove index
    assign w_occ    = 32'(CELL_IDX) < 32'(i_count);
    assign w_at_idx = 32'(CELL_IDX) >= 32'(i_bc.idx);

    // stored key strictly precedes the new key in the current order
    assign o_prec = w_occ && (i_bc.desc ? (r_key > i_bc.key) : (r_key < i_bc.key));

    // first cell whose key does not precede: the insert point
    assign w_head = !i_pre_self && i_pre_prev;
    assign o_pos  = w_head ? 4'(CELL_IDX) : 4'd0;

    // insert: load key at the head, shift up above it; remove: shift down
    always_comb begin
        n_key = r_key;
        if (i_bc.ins && !i_pre_self) begin
            n_key = i_pre_prev ? i_bc.key : i_left_key;
        end else if (i_bc.rem && w_at_idx) begin
            n_key = i_right_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    assign o_key = r_key;

endmodule

/* sv/sorted_key_list.sv */
// Sorted key list: up to CAPACITY 32-bit keys held in ascending or descending order.
// Input channel (i_in_valid / o_in_stall) carries beats of op, key and index:
// insert places the key ahead of the first stored key that does not precede it,
// get reads the key at index, remove deletes the entry at index and closes the gap.
// Output channel (o_out_valid / i_out_stall) returns one beat per request with the
// position, the key read, the entry count after the operation and a status.
// The result beat is registered at the edge that accepts the request.
// Throughput is one request per cycle; every cell compares and
// shifts in parallel, with a log-depth prefix network locating the insert point.
// A request is held off only while a result beat is waiting and stalled.
// i_cfg_we / i_cfg_data write the descending mode bit; change it only while empty.
// Synchronous reset empties the list, drops any pending result beat and selects
// ascending order. Key storage itself is not cleared.
// Depends on skl_pkg, skl_cell, skl_prefix and sorted_key_list_macros.svh.
`timescale 1ns / 1ps

module sorted_key_list #(
    parameter int CAPACITY = skl_pkg::SKL_CAPACITY
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  skl_pkg::t_skl_in  i_in_beat,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output skl_pkg::t_skl_out o_out_beat
);

    import skl_pkg::*;

    `include "sorted_key_list_macros.svh"

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IW    = $clog2(CAPACITY);

    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic                r_desc;
    logic                r_out_valid;
    t_skl_out            r_out;
    t_skl_out            n_out;

    logic                w_acc;
    logic                w_full;
    logic                w_range;
    logic                w_ins_en;
    logic                w_rem_en;
    t_skl_bcast          w_bc;
    logic [KEY_W-1:0]    w_key [CAPACITY];
    logic [3:0]          w_pos_part [CAPACITY];
    logic [CAPACITY-1:0] w_prec;
    logic [CAPACITY-1:0] w_all;
    logic [CAPACITY-1:0] w_prev;
    logic [CAPACITY-1:0] w_head;
    logic [3:0]          w_pos;
    logic [IW-1:0]       w_sel;

    // handshake
    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_acc      = i_in_valid && !o_in_stall;

    // request checks
    assign w_full   = r_count == CNT_W'(CAPACITY);
    assign w_range  = 32'(i_in_beat.index) >= 32'(r_count);
    assign w_ins_en = w_acc && (i_in_beat.op == OP_INSERT) && !w_full;
    assign w_rem_en = w_acc && (i_in_beat.op == OP_REMOVE) && !w_range;
    assign w_sel    = IW'(i_in_beat.index);

    // broadcast to cells
    assign w_bc.ins  = w_ins_en;
    assign w_bc.rem  = w_rem_en;
    assign w_bc.desc = r_desc;
    assign w_bc.key  = i_in_beat.key;
    assign w_bc.idx  = i_in_beat.index;

    // prefix of "precedes" flags finds the insert point
    skl_prefix #(
        .N (CAPACITY)
    ) u_prefix (
        .i_prec (w_prec),
        .o_all  (w_all)
    );

    assign w_prev = {w_all[CAPACITY-2:0], 1'b1};
    assign w_head = w_prev & ~w_all;

    // cell row
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        skl_cell #(
            .CELL_IDX (i),
            .CNT_W    (CNT_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_bc        (w_bc),
            .i_count     (r_count),
            .i_left_key  (w_key[(i == 0) ? 0 : i-1]),
            .i_right_key (w_key[(i == CAPACITY-1) ? i : i+1]),
            .i_pre_prev  (w_prev[i]),
            .i_pre_self  (w_all[i]),
            .o_key       (w_key[i]),
            .o_prec      (w_prec[i]),
            .o_pos       (w_pos_part[i])
        );
    end

    // merge the one-hot position contributions
    always_comb begin
        w_pos = 4'd0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_pos = w_pos | w_pos_part[i];
        end
    end

    // result beat and next count
    always_comb begin
        n_count           = r_count;
        n_out.position    = i_in_beat.index;
        n_out.read_key    = '0;
        n_out.status      = ST_OK;
        case (i_in_beat.op)
            OP_INSERT: begin
                if (w_full) begin
                    n_out.status = ST_FULL;
                end else begin
                    n_out.position = w_pos;
                    n_count        = r_count + 1'b1;
                end
            end
            OP_GET: begin
                if (w_range) begin
                    n_out.status = ST_RANGE;
                end else begin
                    n_out.read_key = w_key[w_sel];
                end
            end
            OP_REMOVE: begin
                if (w_range) begin
                    n_out.status = ST_RANGE;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
        n_out.entries = 5'(n_count);
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_desc      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_desc <= i_cfg_data;
            end
            if (w_acc) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    // checks
    `SKL_ASSERT_RST(a_reset_empty, (!i_rst_n |=> (r_count == '0 && !o_out_valid)), "reset did not empty the list")
    `SKL_ASSERT(a_ins_grows, (w_ins_en |=> (r_count == $past(r_count) + 1'b1)), "insert did not grow the count")
    `SKL_ASSERT(a_rem_shrinks, (w_rem_en |=> (r_count == $past(r_count) - 1'b1)), "remove did not shrink the count")
    `SKL_ASSERT(a_full_refused, ((w_acc && i_in_beat.op == OP_INSERT && w_full) |=> (o_out_beat.status == ST_FULL && r_count == $past(r_count))), "insert into full list not refused")
    `SKL_ASSERT(a_one_head, ((r_count < CNT_W'(CAPACITY)) |-> $onehot(w_head)), "insert point not unique")

endmodule

/* test/sorted_key_list_tb.sv */
// Self-checking testbench for sorted_key_list: directed and random insert/get/remove traffic
// with idling on both channels, checked beat by beat against a tracked copy of the list.
// Depends on skl_pkg and the sorted_key_list RTL.
`timescale 1ns / 1ps

module sorted_key_list_tb;

    import skl_pkg::*;

    // op code the block treats as a no-op
    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         CYCLE_LIMIT = 200000;
    localparam int         PHASES      = 10;
    localparam int         PHASE_BEATS = 85;

    // tracks the list contents and the result beats still owed by the block
    class key_order_scoreboard;
        logic [KEY_W-1:0] shadow_keys[SKL_CAPACITY];
        int               shadow_count;
        bit               shadow_desc;
        t_skl_out         expected_beats[$];
        int               failures;

        function new();
            shadow_count = 0;
            shadow_desc  = 1'b0;
            failures     = 0;
        endfunction

        function void set_mode(bit desc);
            shadow_desc = desc;
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction

        // stored key strictly ahead of the incoming key in the current order
        function bit precedes(logic [KEY_W-1:0] stored, logic [KEY_W-1:0] incoming);
            return shadow_desc ? (stored > incoming) : (stored < incoming);
        endfunction

        // update the tracked list for one accepted request and queue its result
        function void accept_request(t_skl_in req);
            t_skl_out exp_beat;
            int       slot;
            int       i;
            exp_beat          = '0;
            exp_beat.position = req.index;
            exp_beat.status   = ST_OK;
            case (req.op)
                OP_INSERT: begin
                    if (shadow_count >= SKL_CAPACITY) begin
                        exp_beat.status = ST_FULL;
                    end else begin
                        slot = 0;
                        while (slot < shadow_count && precedes(shadow_keys[slot], req.key))
                            slot++;
                        for (i = shadow_count; i > slot; i--)
                            shadow_keys[i] = shadow_keys[i-1];
                        shadow_keys[slot] = req.key;
                        shadow_count++;
                        exp_beat.position = 4'(slot);
                    end
                end
                OP_GET: begin
                    if (int'(req.index) >= shadow_count)
                        exp_beat.status = ST_RANGE;
                    else
                        exp_beat.read_key = shadow_keys[req.index];
                end
                OP_REMOVE: begin
                    if (int'(req.index) >= shadow_count) begin
                        exp_beat.status = ST_RANGE;
                    end else begin
                        for (i = int'(req.index); i + 1 < shadow_count; i++)
                            shadow_keys[i] = shadow_keys[i+1];
                        shadow_count--;
                    end
                end
                default: ;
            endcase
            exp_beat.entries = 5'(shadow_count);
            expected_beats.push_back(exp_beat);
        endfunction

        // compare one result beat with the oldest expectation
        function void check_result(t_skl_out got);
            t_skl_out exp_beat;
            if (expected_beats.size() == 0) begin
                $error("unexpected result beat %h", got);
                failures++;
                return;
            end
            exp_beat = expected_beats.pop_front();
            if (got.position !== exp_beat.position) begin
                $error("position: expected %0d, got %0d", exp_beat.position, got.position);
                failures++;
            end
            if (got.read_key !== exp_beat.read_key) begin
                $error("read_key: expected %h, got %h", exp_beat.read_key, got.read_key);
                failures++;
            end
            if (got.entries !== exp_beat.entries) begin
                $error("entries: expected %0d, got %0d", exp_beat.entries, got.entries);
                failures++;
            end
            if (got.status !== exp_beat.status) begin
                $error("status: expected %0d, got %0d", exp_beat.status, got.status);
                failures++;
            end
        endfunction
    endclass

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     cfg_we    = 1'b0;
    logic     cfg_data  = 1'b0;
    logic     in_valid  = 1'b0;
    t_skl_in  in_beat   = '0;
    logic     out_stall = 1'b0;
    logic     in_stall;
    logic     out_valid;
    t_skl_out out_beat;

    bit                  calm = 1'b0;
    int                  cycles = 0;
    key_order_scoreboard board = new();

    sorted_key_list i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_beat  (out_beat)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // run limit
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // random back-pressure on the result channel
    always @(posedge clk) begin
        out_stall <= !calm && ($urandom_range(99) < 30);
    end

    // result beats
    always @(posedge clk) begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
            board.check_result(out_beat);
    end

    function automatic t_skl_in make_beat(logic [1:0] op, logic [KEY_W-1:0] key,
                                          logic [3:0] idx);
        t_skl_in b;
        b.op    = op;
        b.key   = key;
        b.index = idx;
        return b;
    endfunction

    // present one request beat, with random idle cycles ahead of it
    task automatic send_request(t_skl_in req);
        if (!calm && $urandom_range(99) < 30) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < 30);
        end
        in_valid <= 1'b1;
        in_beat  <= req;
        do @(posedge clk); while (in_stall !== 1'b0);
        board.accept_request(req);
    endtask

    // write the mode bit once every owed result has arrived
    task automatic write_mode(bit desc);
        in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= desc;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.set_mode(desc);
    endtask

    function automatic logic [KEY_W-1:0] random_key();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return KEY_W'($urandom_range(7));
            default: return $urandom;
        endcase
    endfunction

    // random request; insert_pct sets how hard the list is pushed toward full
    function automatic t_skl_in random_request(int insert_pct);
        logic [1:0] op;
        logic [3:0] idx;
        int         r;
        r = $urandom_range(99);
        if (r == 99)
            op = OP_UNUSED;
        else if (r < insert_pct)
            op = OP_INSERT;
        else if ($urandom_range(1) == 0)
            op = OP_GET;
        else
            op = OP_REMOVE;
        if (board.shadow_count > 0 && $urandom_range(99) < 80)
            idx = 4'($urandom_range(board.shadow_count - 1));
        else
            idx = 4'($urandom_range(15));
        return make_beat(op, random_key(), idx);
    endfunction

    initial begin
        int insert_pct;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        write_mode(1'b0);

        // directed: empty list, extremes, duplicates, unused op, range errors
        send_request(make_beat(OP_GET,    '0,           4'd0));
        send_request(make_beat(OP_REMOVE, '0,           4'd15));
        send_request(make_beat(OP_INSERT, 32'd5,        4'd9));
        send_request(make_beat(OP_INSERT, '1,           4'd0));
        send_request(make_beat(OP_INSERT, '0,           4'd0));
        send_request(make_beat(OP_INSERT, 32'd5,        4'd15));
        send_request(make_beat(OP_UNUSED, 32'hDEADBEEF, 4'd10));
        send_request(make_beat(OP_GET,    '0,           4'd0));
        send_request(make_beat(OP_GET,    '0,           4'd3));
        send_request(make_beat(OP_GET,    '1,           4'd4));
        send_request(make_beat(OP_REMOVE, '0,           4'd1));
        send_request(make_beat(OP_GET,    '0,           4'd1));
        send_request(make_beat(OP_REMOVE, '0,           4'd2));
        send_request(make_beat(OP_REMOVE, '0,           4'd15));
        send_request(make_beat(OP_INSERT, 32'h80000000, 4'd0));

        // mode flip with keys still stored
        write_mode(1'b1);
        send_request(make_beat(OP_INSERT, 32'h7FFFFFFF, 4'd0));
        send_request(make_beat(OP_INSERT, '1,           4'd0));
        send_request(make_beat(OP_INSERT, '0,           4'd0));
        send_request(make_beat(OP_GET,    '0,           4'd0));
        send_request(make_beat(OP_GET,    '0,           4'd4));

        // random phases; every third one fills the list to refusal
        for (int p = 0; p < PHASES; p++) begin
            if (p < 2)
                write_mode(p[0]);
            else
                write_mode(1'($urandom_range(1)));
            calm       = (p == 4);
            insert_pct = (p % 3 == 0) ? 80 : $urandom_range(25, 65);
            for (int n = 0; n < PHASE_BEATS; n++)
                send_request(random_request(insert_pct));
        end
        calm = 1'b0;

        // drain
        in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        if (board.failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* sorted_key_list.f */
+incdir+sv
sv/skl_pkg.sv
sv/skl_prefix.sv
sv/skl_cell.sv
sv/sorted_key_list.sv
test/sorted_key_list_tb.sv
